### rtl/ame_pkg.sv
// Package: opcodes, states and controller/datapath command types for the execute unit.
package ame_pkg;

  localparam int unsigned FUNC_W = 5;
  localparam int unsigned ARG_W  = 32;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_CLEAR    = 5'd0,
    OP_LOAD     = 5'd1,
    OP_STORE    = 5'd2,
    OP_INSERT   = 5'd3,
    OP_ERASE    = 5'd4,
    OP_ADDC     = 5'd5,
    OP_SUBC     = 5'd6,
    OP_MULC     = 5'd7,
    OP_DIVC     = 5'd8,
    OP_ADDM     = 5'd9,
    OP_SUBM     = 5'd10,
    OP_MULM     = 5'd11,
    OP_DIVM     = 5'd12,
    OP_JUMP     = 5'd13,
    OP_JZ       = 5'd14,
    OP_JNZ      = 5'd15,
    OP_NOP      = 5'd16,
    OP_HALT     = 5'd17,
    OP_OUTPUT   = 5'd18,
    OP_CHECKMEM = 5'd19,
    OP_APPEND   = 5'd20,
    OP_READBACK = 5'd21
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_RUNNING = 2'd0,
    ST_HALTED  = 2'd1,
    ST_ERRORED = 2'd2
  } run_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_DECODE,
    C_READ,
    C_READ_WAIT,
    C_EXEC,
    C_MUL,
    C_DIV,
    C_DIV_FIX,
    C_SHIFT_UP,
    C_SHIFT_DOWN,
    C_FINISH,
    C_OUT
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;       // capture input beat
    logic rd_arg;      // issue memory read at argument
    logic exec;        // execute stage of every instruction
    logic mul_start;
    logic mul_step;
    logic div_start;
    logic div_step;
    logic div_fix;
    logic up_start;
    logic up_step;
    logic dn_start;
    logic dn_step;
    logic finish;      // commit length for insert/erase; insert also writes the accumulator
    logic out_load;    // load output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              running;
    logic              idx_ok;
    logic              ins_ok;
    logic              zero_div;
    logic              mul_done;
    logic              div_done;
    logic              shift_done;
  } stat_t;

endpackage

### rtl/ame_datapath.sv
// Datapath: accumulator, data memory, shift sequencer, multiply and divide units.
module ame_datapath #(
  parameter int unsigned MEM_DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ame_pkg::cmd_t                         cmd,
  output ame_pkg::stat_t                        st,
  input  logic [ame_pkg::FUNC_W-1:0]            func,
  input  logic signed [ame_pkg::ARG_W-1:0]      argument,
  input  logic signed [ame_pkg::WORD_W-1:0]     data_word,
  output logic signed [ame_pkg::ARG_W-1:0]      jump_distance,
  output logic signed [ame_pkg::WORD_W-1:0]     acc_value,
  output logic [ame_pkg::STAT_W-1:0]            run_status,
  output logic                                  print_strobe,
  output logic signed [ame_pkg::WORD_W-1:0]     read_word,
  output logic [ame_pkg::LEN_W-1:0]             mem_length
);
  import ame_pkg::*;

  localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned CW = $clog2(MEM_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(MEM_DEPTH);

  // latched instruction
  logic [FUNC_W-1:0] f;
  logic [ARG_W-1:0]  a;
  logic [WORD_W-1:0] dw;

  logic [WORD_W-1:0] acc;
  logic [CW-1:0]     len;
  run_t              state;
  logic [WORD_W-1:0] mword;

  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata;

  // shift sequencer
  logic [CW-1:0] sp;
  logic [CW-1:0] sp_next;

  // multiplier: 16 bits of the operand per step
  logic [WORD_W-1:0] m_a, m_b, m_p;
  logic [1:0]        m_cnt;

  // restoring divider, one bit per step
  logic [WORD_W-1:0] d_q, d_r, d_d;
  logic [6:0]        d_cnt;
  logic              d_neg;

  logic [ARG_W-1:0]  jd;
  logic              strobe;
  logic [WORD_W-1:0] rw;

  logic [WORD_W-1:0] opnd, arg_sx;
  logic              a_neg;
  logic [CW:0]       a_lo;
  logic              idx_ok, ins_ok;
  logic [WORD_W:0]   d_trial;
  logic [WORD_W-1:0] m_part;

  assign arg_sx = {{(WORD_W-ARG_W){a[ARG_W-1]}}, a};
  assign a_neg  = a[ARG_W-1];
  assign a_lo   = (ARG_W > CW) ? ((a[ARG_W-2:0] > (ARG_W-1)'(MEM_DEPTH)) ? {1'b1, {CW{1'b1}}}
                                   : (CW+1)'(a[ARG_W-2:0])) : (CW+1)'(a);
  assign idx_ok = !a_neg && (a_lo < {1'b0, len});
  assign ins_ok = !a_neg && (a_lo <= {1'b0, len}) && (len < DEPTH_C);
  assign opnd   = (f >= OP_ADDM && f <= OP_DIVM) ? mword : arg_sx;

  assign st.func       = f;
  assign st.running    = (state == ST_RUNNING);
  assign st.idx_ok     = idx_ok;
  assign st.ins_ok     = ins_ok;
  assign st.zero_div   = (opnd == '0);
  assign st.mul_done   = (m_cnt == 2'd3);
  assign st.div_done   = (d_cnt == 7'd63);
  assign st.shift_done = (f == OP_INSERT) ? (sp <= a_lo[CW-1:0]) : (sp + 1'b1 >= len);

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    mword <= mem[raddr];
  end

  always_comb begin
    we      = 1'b0;
    waddr   = a[AW-1:0];
    wdata   = acc;
    raddr   = a[AW-1:0];
    sp_next = sp;
    if (cmd.rd_arg) raddr = a[AW-1:0];
    if (cmd.up_start) begin
      raddr = AW'(len - 1'b1);
    end else if (cmd.up_step) begin
      // mword holds mem[sp-1]; write it to sp
      we      = 1'b1;
      waddr   = sp[AW-1:0];
      wdata   = mword;
      sp_next = sp - 1'b1;
      raddr   = AW'(sp - 2'd2);
    end else if (cmd.dn_start) begin
      raddr = AW'(a_lo[CW-1:0] + 1'b1);
    end else if (cmd.dn_step) begin
      we      = 1'b1;
      waddr   = sp[AW-1:0];
      wdata   = mword;
      sp_next = sp + 1'b1;
      raddr   = AW'(sp + 2'd2);
    end else if (cmd.finish && f == OP_INSERT) begin
      we    = 1'b1;
      waddr = a[AW-1:0];
      wdata = acc;
    end else if (cmd.exec && f == OP_STORE && state == ST_RUNNING && idx_ok) begin
      we = 1'b1;
    end else if (cmd.exec && f == OP_APPEND && len < DEPTH_C) begin
      we    = 1'b1;
      waddr = len[AW-1:0];
      wdata = dw;
    end
  end

  assign m_part = m_a * {48'd0, m_b[15:0]};
  // shifted partial remainder minus divisor; the top bit flags a borrow
  assign d_trial = {1'b0, d_r[WORD_W-2:0], d_q[WORD_W-1]} - {1'b0, d_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      len   <= '0;
      state <= ST_RUNNING;
    end else begin
      if (cmd.exec) begin
        case (f)
          OP_APPEND: begin
            if (len < DEPTH_C) len <= len + 1'b1;
            else state <= ST_ERRORED;
          end
          OP_READBACK: ;
          default: begin
            if (state == ST_RUNNING) begin
              case (f)
                OP_CLEAR: acc <= '0;
                OP_LOAD, OP_STORE, OP_ERASE, OP_ADDM, OP_SUBM, OP_MULM, OP_DIVM:
                  if (!idx_ok) state <= ST_ERRORED;
                  else if (f == OP_LOAD) acc <= mword;
                  else if (f == OP_ADDM) acc <= acc + opnd;
                  else if (f == OP_SUBM) acc <= acc - opnd;
                  else if (f == OP_DIVM && opnd == '0) state <= ST_ERRORED;
                OP_INSERT: if (!ins_ok) state <= ST_ERRORED;
                OP_ADDC:   acc <= acc + opnd;
                OP_SUBC:   acc <= acc - opnd;
                OP_DIVC:   if (opnd == '0) state <= ST_ERRORED;
                OP_HALT:   state <= ST_HALTED;
                OP_CHECKMEM: if (!a_neg && a_lo > {1'b0, len}) state <= ST_ERRORED;
                default: ;
              endcase
            end
          end
        endcase
      end
      if (cmd.finish && f == OP_INSERT) len <= len + 1'b1;
      if (cmd.finish && f == OP_ERASE)  len <= len - 1'b1;
      if (cmd.mul_step && m_cnt == 2'd3) acc <= m_p + (m_part << 48);
      if (cmd.div_fix) acc <= d_neg ? (0 - d_q) : d_q;
    end
  end

  // payload-only registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      f  <= func;
      a  <= argument;
      dw <= data_word;
    end
    if (cmd.up_start) sp <= len;
    else if (cmd.dn_start) sp <= a_lo[CW-1:0];
    else sp <= sp_next;
    if (cmd.mul_start) begin
      m_a   <= acc;
      m_b   <= opnd;
      m_p   <= '0;
      m_cnt <= '0;
    end else if (cmd.mul_step) begin
      m_p   <= m_p + (m_part << {m_cnt, 4'd0});
      m_b   <= m_b >> 16;
      m_cnt <= m_cnt + 1'b1;
    end
    if (cmd.div_start) begin
      d_neg <= acc[WORD_W-1] ^ opnd[WORD_W-1];
      d_q   <= acc[WORD_W-1] ? (0 - acc) : acc;
      d_d   <= opnd[WORD_W-1] ? (0 - opnd) : opnd;
      d_r   <= '0;
      d_cnt <= '0;
    end else if (cmd.div_step) begin
      if (!d_trial[WORD_W]) begin
        d_r <= d_trial[WORD_W-1:0];
        d_q <= {d_q[WORD_W-2:0], 1'b1};
      end else begin
        d_r <= {d_r[WORD_W-2:0], d_q[WORD_W-1]};
        d_q <= {d_q[WORD_W-2:0], 1'b0};
      end
      d_cnt <= d_cnt + 1'b1;
    end
    if (cmd.exec) begin
      jd     <= 32'sd1;
      strobe <= 1'b0;
      rw     <= '0;
      if (f == OP_READBACK && idx_ok) rw <= mword;
      if (state == ST_RUNNING) begin
        if (f == OP_JUMP || (f == OP_JZ && acc == '0) || (f == OP_JNZ && acc != '0)) jd <= a;
        if (f == OP_OUTPUT) strobe <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      jump_distance <= jd;
      acc_value     <= acc;
      run_status    <= state;
      print_strobe  <= strobe;
      read_word     <= rw;
      mem_length    <= LEN_W'(len);
    end
  end

endmodule

### rtl/ame_control.sv
// Controller: sequences each instruction through read, execute and multi-cycle steps.
module ame_control (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ame_pkg::stat_t st,
  output ame_pkg::cmd_t  cmd
);
  import ame_pkg::*;

  ctl_state_t state, state_next;
  logic       ovalid, ovalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= C_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
  end

  assign out_valid = ovalid;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    ovalid_next = ovalid && !out_ready;
    in_ready    = (state == C_IDLE);
    case (state)
      C_IDLE: if (in_valid) begin
        cmd.latch  = 1'b1;
        state_next = C_DECODE;
      end
      C_DECODE: begin
        cmd.rd_arg = 1'b1;
        state_next = C_READ_WAIT;
      end
      C_READ, C_READ_WAIT: state_next = C_EXEC;
      C_EXEC: begin
        state_next = C_FINISH;
        if (st.running && (st.func == OP_MULC || (st.func == OP_MULM && st.idx_ok))) begin
          cmd.mul_start = 1'b1;
          state_next    = C_MUL;
        end else if (st.running && !st.zero_div &&
                     (st.func == OP_DIVC || (st.func == OP_DIVM && st.idx_ok))) begin
          cmd.div_start = 1'b1;
          state_next    = C_DIV;
        end else if (st.running && st.func == OP_INSERT && st.ins_ok) begin
          cmd.up_start = 1'b1;
          state_next   = C_SHIFT_UP;
        end else if (st.running && st.func == OP_ERASE && st.idx_ok) begin
          cmd.dn_start = 1'b1;
          state_next   = C_SHIFT_DOWN;
        end
        cmd.exec = 1'b1;
      end
      C_MUL: begin
        cmd.mul_step = 1'b1;
        if (st.mul_done) state_next = C_OUT;
      end
      C_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) state_next = C_DIV_FIX;
      end
      C_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_next  = C_OUT;
      end
      C_SHIFT_UP: begin
        if (st.shift_done) begin
          cmd.finish = 1'b1;
          state_next = C_OUT;
        end else cmd.up_step = 1'b1;
      end
      C_SHIFT_DOWN: begin
        if (st.shift_done) begin
          cmd.finish = 1'b1;
          state_next = C_OUT;
        end else cmd.dn_step = 1'b1;
      end
      C_FINISH: state_next = C_OUT;
      C_OUT: if (!ovalid || out_ready) begin
        cmd.out_load = 1'b1;
        ovalid_next  = 1'b1;
        state_next   = C_IDLE;
      end
      default: state_next = C_IDLE;
    endcase
  end

endmodule

### rtl/accumulator_machine_execute.sv
// Top level: execute unit of a one-accumulator machine.
//
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------------------
//  in      | in_valid / in_ready      | func, argument, data_word
//  out     | out_valid / out_ready    | jump_distance, acc_value, run_status,
//          |                          | print_strobe, read_word, mem_length
//
// Sequence per beat for plain ops: latch, memory read, wait, execute, finish,
// result; multiply runs 4 steps of a 64x16 unit in place of the finish
// step, divide 64 steps of a bit-serial divider plus a sign fix, and
// insert/erase one step per shifted word through the memory's one write port.
// Reset clears accumulator, length and status; memory contents stay undefined.
// Output register holds a result while out_ready is low; the next beat is
// taken meanwhile, and its result waits until the register frees.
module accumulator_machine_execute #(
  parameter int unsigned MEM_DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ame_pkg::FUNC_W-1:0]            func,
  input  logic signed [ame_pkg::ARG_W-1:0]      argument,
  input  logic signed [ame_pkg::WORD_W-1:0]     data_word,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ame_pkg::ARG_W-1:0]      jump_distance,
  output logic signed [ame_pkg::WORD_W-1:0]     acc_value,
  output logic [ame_pkg::STAT_W-1:0]            run_status,
  output logic                                  print_strobe,
  output logic signed [ame_pkg::WORD_W-1:0]     read_word,
  output logic [ame_pkg::LEN_W-1:0]             mem_length
);
  import ame_pkg::*;

  cmd_t  cmd;
  stat_t st;

  ame_control u_ctl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .st, .cmd
  );

  ame_datapath #(.MEM_DEPTH(MEM_DEPTH)) u_dp (
    .clk, .rst, .cmd, .st, .func, .argument, .data_word,
    .jump_distance, .acc_value, .run_status, .print_strobe, .read_word, .mem_length
  );

endmodule

### bench/accumulator_machine_execute_tb.sv
// Testbench for the accumulator machine execute unit: directed table plus random programs.
`timescale 1ns / 100ps

module accumulator_machine_execute_tb;
  import ame_pkg::*;

  localparam int DEPTH       = 256;
  localparam int RAND_ITEMS  = 600;
  localparam int NOISE_ITEMS = 50;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SHORT_LEN   = 40;   // keep shifts short in the random part
  localparam int N_ROWS      = 26;

  typedef struct packed {
    logic [31:0] jd;
    logic [63:0] acc;
    logic [1:0]  st;
    logic        strobe;
    logic [63:0] rw;
    logic [8:0]  len;
  } result_t;

  typedef struct packed {
    logic [4:0]  f;
    logic [31:0] a;
    logic [63:0] d;
    logic        typed;
    result_t     r;
  } row_t;

  localparam logic [63:0] WMIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] WMAX = 64'h7FFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  func = '0;
  logic [31:0] argument = '0;
  logic [63:0] data_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [31:0] jump_distance;
  logic signed [63:0] acc_value;
  logic [1:0]  run_status;
  logic        print_strobe;
  logic signed [63:0] read_word;
  logic [8:0]  mem_length;

  accumulator_machine_execute dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: accumulator, data memory, length and run status.
  logic [63:0] m_acc;
  logic [63:0] m_mem [DEPTH];
  int          m_len;
  logic [1:0]  m_st;

  result_t pending_results [$];
  int      fails = 0;
  int      cycles = 0;
  row_t    rows [N_ROWS];

  function automatic logic [63:0] trunc_div(logic [63:0] n, logic [63:0] d);
    longint sn, sd;
    sn = n;
    sd = d;
    // Most negative over minus one wraps back to itself.
    if (sd == -1) return 64'd0 - n;
    return sn / sd;
  endfunction

  // Advance the machine model by one instruction and return its result.
  function automatic result_t execute_instr(logic [4:0] f, logic [31:0] a, logic [63:0] d);
    result_t r;
    longint  idx;
    logic [63:0] sarg, m, opnd;
    bit memop, idx_ok;
    idx  = $signed(a);
    sarg = {{32{a[31]}}, a};
    r.jd = 32'd1;
    r.strobe = 1'b0;
    r.rw = '0;
    idx_ok = idx >= 0 && idx < m_len;
    if (f == OP_APPEND) begin
      if (m_len < DEPTH) begin
        m_mem[m_len] = d;
        m_len++;
      end else m_st = ST_ERRORED;
    end else if (f == OP_READBACK) begin
      if (idx_ok) r.rw = m_mem[idx];
    end else if (m_st == ST_RUNNING) begin
      memop = f inside {OP_LOAD, OP_STORE, OP_ERASE} || (f >= OP_ADDM && f <= OP_DIVM);
      if (memop && !idx_ok) m_st = ST_ERRORED;
      else begin
        m = memop ? m_mem[idx] : '0;
        opnd = (f >= OP_ADDM && f <= OP_DIVM) ? m : sarg;
        case (f)
          OP_CLEAR: m_acc = '0;
          OP_LOAD:  m_acc = m;
          OP_STORE: m_mem[idx] = m_acc;
          OP_INSERT: begin
            if (idx < 0 || idx > m_len || m_len >= DEPTH) m_st = ST_ERRORED;
            else begin
              for (int i = m_len; i > idx; i--) m_mem[i] = m_mem[i-1];
              m_mem[idx] = m_acc;
              m_len++;
            end
          end
          OP_ERASE: begin
            for (int i = int'(idx); i + 1 < m_len; i++) m_mem[i] = m_mem[i+1];
            m_len--;
          end
          OP_ADDC, OP_ADDM: m_acc = m_acc + opnd;
          OP_SUBC, OP_SUBM: m_acc = m_acc - opnd;
          OP_MULC, OP_MULM: m_acc = m_acc * opnd;
          OP_DIVC, OP_DIVM: begin
            if (opnd == 0) m_st = ST_ERRORED;
            else m_acc = trunc_div(m_acc, opnd);
          end
          OP_JUMP:     r.jd = a;
          OP_JZ:       if (m_acc == 0) r.jd = a;
          OP_JNZ:      if (m_acc != 0) r.jd = a;
          OP_HALT:     m_st = ST_HALTED;
          OP_OUTPUT:   r.strobe = 1'b1;
          OP_CHECKMEM: if (idx > m_len) m_st = ST_ERRORED;
          default: ;
        endcase
      end
    end
    r.acc = m_acc;
    r.st  = m_st;
    r.len = m_len[8:0];
    return r;
  endfunction

  // Input side: random gap, then hold the beat until it is taken.
  int  sent = 0;
  bit  in_calm = 1'b0;

  task automatic send_beat(logic [4:0] f, logic [31:0] a, logic [63:0] d,
                           bit typed, result_t typed_res);
    int gap;
    result_t r;
    if (sent % 64 == 0) in_calm = $urandom_range(0, 3) == 0;
    gap = in_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    func      <= f;
    argument  <= a;
    data_word <= d;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    r = execute_instr(f, a, d);
    pending_results = {pending_results, (typed ? typed_res : r)};
    sent++;
  endtask

  // Well-formed instruction: indices in range, no zero divisors, no halt.
  task automatic pick_clean(output logic [4:0] f, output logic [31:0] a,
                            output logic [63:0] d);
    f = 5'($urandom_range(0, 31));
    a = $urandom();
    d = {$urandom(), $urandom()};
    if ($urandom_range(0, 3) == 0) a = $urandom_range(0, 15) - 8;
    if ((f == OP_APPEND || f == OP_INSERT) && m_len > SHORT_LEN) f = OP_ERASE;
    if (f == OP_HALT) f = OP_OUTPUT;
    if ((f inside {OP_LOAD, OP_STORE, OP_ERASE} || (f >= OP_ADDM && f <= OP_DIVM))
        && m_len == 0) f = OP_APPEND;
    case (f)
      OP_LOAD, OP_STORE, OP_ERASE, OP_ADDM, OP_SUBM, OP_MULM, OP_DIVM: begin
        a = $urandom_range(0, m_len - 1);
        if (f == OP_DIVM && m_mem[a] == 0) f = OP_ADDM;
      end
      OP_INSERT:   a = $urandom_range(0, m_len);
      OP_DIVC:     if (a == 0) a = 32'd1;
      OP_CHECKMEM: a = $urandom_range(0, 1) ? $urandom_range(0, m_len) : ($urandom() | 32'h8000_0000);
      OP_READBACK: if ($urandom_range(0, 1) && m_len > 0) a = $urandom_range(0, m_len - 1);
      default: ;
    endcase
  endtask

  initial begin
    logic [4:0]  f;
    logic [31:0] a;
    logic [63:0] d;
    int kind;
    rows = '{
      '{OP_NOP,      32'd0,        64'd0, 1'b1, '{32'd1,   64'd0, ST_RUNNING, 1'b0, 64'd0, 9'd0}},
      '{OP_READBACK, 32'd0,        64'd0, 1'b1, '{32'd1,   64'd0, ST_RUNNING, 1'b0, 64'd0, 9'd0}},
      '{OP_APPEND,   32'd0,        WMIN,  1'b1, '{32'd1,   64'd0, ST_RUNNING, 1'b0, 64'd0, 9'd1}},
      '{OP_APPEND,   32'd0,        WMAX,  1'b1, '{32'd1,   64'd0, ST_RUNNING, 1'b0, 64'd0, 9'd2}},
      '{OP_LOAD,     32'd0,        64'd0, 1'b1, '{32'd1,   WMIN,  ST_RUNNING, 1'b0, 64'd0, 9'd2}},
      '{OP_DIVC,     32'hFFFFFFFF, 64'd0, 1'b1, '{32'd1,   WMIN,  ST_RUNNING, 1'b0, 64'd0, 9'd2}},
      '{OP_READBACK, 32'd1,        64'd0, 1'b1, '{32'd1,   WMIN,  ST_RUNNING, 1'b0, WMAX,  9'd2}},
      '{OP_ADDM,     32'd1,        64'd0, 1'b1, '{32'd1,   '1,    ST_RUNNING, 1'b0, 64'd0, 9'd2}},
      '{OP_MULC,     32'h7FFFFFFF, 64'd0, 1'b0, '0},
      '{OP_SUBC,     32'h80000000, 64'd0, 1'b0, '0},
      '{OP_DIVC,     32'd7,        64'd0, 1'b0, '0},
      '{OP_JZ,       32'd5,        64'd0, 1'b0, '0},
      '{OP_JNZ,      32'hFFFFFFFD, 64'd0, 1'b0, '0},
      '{OP_JUMP,     32'h80000000, 64'd0, 1'b0, '0},
      '{OP_CLEAR,    32'd0,        64'd0, 1'b1, '{32'd1,   64'd0, ST_RUNNING, 1'b0, 64'd0, 9'd2}},
      '{OP_JZ,       32'd100,      64'd0, 1'b1, '{32'd100, 64'd0, ST_RUNNING, 1'b0, 64'd0, 9'd2}},
      '{OP_JNZ,      32'd9,        64'd0, 1'b1, '{32'd1,   64'd0, ST_RUNNING, 1'b0, 64'd0, 9'd2}},
      '{OP_INSERT,   32'd0,        64'd0, 1'b1, '{32'd1,   64'd0, ST_RUNNING, 1'b0, 64'd0, 9'd3}},
      '{OP_STORE,    32'd2,        64'd0, 1'b0, '0},
      '{OP_ERASE,    32'd1,        64'd0, 1'b0, '0},
      '{OP_OUTPUT,   32'd0,        64'd0, 1'b0, '0},
      '{OP_CHECKMEM, 32'hFFFFFFFB, 64'd0, 1'b0, '0},
      '{OP_CHECKMEM, 32'd2,        64'd0, 1'b0, '0},
      '{5'd31,       32'hFFFFFFFF, '1,    1'b0, '0},
      '{OP_SUBM,     32'd0,        64'd0, 1'b0, '0},
      '{OP_MULM,     32'd1,        64'd0, 1'b0, '0}
    };
    m_acc = '0;
    m_len = 0;
    m_st  = ST_RUNNING;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_beat(rows[i].f, rows[i].a, rows[i].d, rows[i].typed, rows[i].r);

    repeat (RAND_ITEMS) begin
      pick_clean(f, a, d);
      send_beat(f, a, d, 1'b0, '0);
    end

    // Drive the machine into one sticky stop, picked at random.
    kind = $urandom_range(0, 5);
    if (kind >= 4) begin
      while (m_len < DEPTH) send_beat(OP_APPEND, $urandom(), {$urandom(), $urandom()}, 1'b0, '0);
    end
    case (kind)
      0: send_beat(OP_LOAD, m_len, '0, 1'b0, '0);
      1: send_beat(OP_DIVC, '0, '0, 1'b0, '0);
      2: send_beat(OP_HALT, '0, '0, 1'b0, '0);
      3: send_beat(OP_CHECKMEM, m_len + 1, '0, 1'b0, '0);
      4: send_beat(OP_INSERT, '0, '0, 1'b0, '0);
      default: send_beat(OP_APPEND, '0, {$urandom(), $urandom()}, 1'b0, '0);
    endcase

    // Noise after the stop: only host opcodes may still act.
    repeat (NOISE_ITEMS) begin
      a = $urandom_range(0, 1) ? $urandom_range(0, m_len + 3) : $urandom();
      send_beat(5'($urandom_range(0, 31)), a, {$urandom(), $urandom()}, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Output side: random stall per beat; calm stretches chosen at random every 64 beats.
  initial begin
    int stall, got;
    bit out_calm;
    result_t e;
    got = 0;
    out_calm = 1'b0;
    @(negedge rst);
    forever begin
      if (got % 64 == 0) out_calm = $urandom_range(0, 3) == 0;
      stall = out_calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        e = pending_results.pop_front();
        if (jump_distance !== e.jd) begin
          $error("jump_distance exp %0d got %0d", $signed(e.jd), jump_distance); fails++;
        end
        if (acc_value !== e.acc) begin
          $error("acc_value exp %h got %h", e.acc, acc_value); fails++;
        end
        if (run_status !== e.st) begin
          $error("run_status exp %0d got %0d", e.st, run_status); fails++;
        end
        if (print_strobe !== e.strobe) begin
          $error("print_strobe exp %0d got %0d", e.strobe, print_strobe); fails++;
        end
        if (read_word !== e.rw) begin
          $error("read_word exp %h got %h", e.rw, read_word); fails++;
        end
        if (mem_length !== e.len) begin
          $error("mem_length exp %0d got %0d", e.len, mem_length); fails++;
        end
      end
    end
  end

  // Watchdog: end the run with a failure once the cycle limit is reached.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

### accumulator_machine_execute.f
rtl/ame_pkg.sv
rtl/ame_datapath.sv
rtl/ame_control.sv
rtl/accumulator_machine_execute.sv
bench/accumulator_machine_execute_tb.sv
